/* rtl/nvsc_pkg.sv */
// Shared types and constants for the NV12 nearest-neighbor scaler address generator.
// No dependencies; imported by nvsc_div and nv12_nearest_scaler_address.
package nvsc_pkg;

    // Field and datapath widths
    localparam int COORD_W = 13;
    localparam int DIM_W   = 14;
    localparam int STR_W   = 15;
    localparam int QUO_W   = 14;
    localparam int NUM_W   = COORD_W + DIM_W;
    localparam int OFF_W   = 27;

    // Saturation limits for the frame registers
    localparam int MAX_DIM    = 8192;
    localparam int MAX_STRIDE = 16384;
    localparam int DIM_HI_I   = (MAX_DIM > (2**DIM_W - 1)) ? (2**DIM_W - 1) : MAX_DIM;
    localparam int STR_HI_I   = (MAX_STRIDE > (2**STR_W - 1)) ? (2**STR_W - 1) : MAX_STRIDE;
    localparam logic [DIM_W-1:0] DIM_LO = DIM_W'(2);
    localparam logic [DIM_W-1:0] DIM_HI = DIM_W'(DIM_HI_I);
    localparam logic [STR_W-1:0] STR_LO = STR_W'(2);
    localparam logic [STR_W-1:0] STR_HI = STR_W'(STR_HI_I);

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_ODD     = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_SRC_W      = 3'd0;
    localparam logic [2:0] REG_SRC_H      = 3'd1;
    localparam logic [2:0] REG_DST_W      = 3'd2;
    localparam logic [2:0] REG_DST_H      = 3'd3;
    localparam logic [2:0] REG_LUMA_STR   = 3'd4;
    localparam logic [2:0] REG_CHROMA_STR = 3'd5;
    localparam logic [2:0] REG_DST_STR    = 3'd6;

    // Register reset values
    localparam logic [DIM_W-1:0] RST_SRC_W      = DIM_W'(3840);
    localparam logic [DIM_W-1:0] RST_SRC_H      = DIM_W'(2160);
    localparam logic [DIM_W-1:0] RST_DST_W      = DIM_W'(1920);
    localparam logic [DIM_W-1:0] RST_DST_H      = DIM_W'(1080);
    localparam logic [STR_W-1:0] RST_LUMA_STR   = STR_W'(3840);
    localparam logic [STR_W-1:0] RST_CHROMA_STR = STR_W'(3840);
    localparam logic [STR_W-1:0] RST_DST_STR    = STR_W'(1920);

    // Per-item sideband carried alongside the dividers
    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [1:0]         status;
    } t_side;

endpackage

/* rtl/nvsc_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nvsc_pkg for widths.
module nvsc_div
    import nvsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DIM_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    localparam int REM_W = DIM_W + QUO_W;

    logic [REM_W-1:0] r_rem [QUO_W-1];
    logic [DIM_W-1:0] r_den [QUO_W-1];
    logic [QUO_W-1:0] r_quo [QUO_W];

    // Stage s decides quotient bit QUO_W-1-s; exact while num < den * 2^QUO_W
    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [REM_W-1:0] den_sh;
        logic [DIM_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [QUO_W-1:0] n_quo;
        logic             ge;

        if (s == 0) begin : g_first
            assign rem_in = REM_W'(i_num);
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end

        assign den_sh = REM_W'(den_in) << (QUO_W - 1 - s);
        assign ge     = (rem_in >= den_sh);
        assign n_quo  = quo_in | (QUO_W'(ge) << (QUO_W - 1 - s));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[s] <= n_quo;
            end
        end

        // partial remainder and divisor move on to the next bit
        if (s < QUO_W - 1) begin : g_carry
            logic [REM_W-1:0] n_rem;
            assign n_rem = ge ? (rem_in - den_sh) : rem_in;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem;
                    r_den[s] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

/* rtl/nv12_nearest_scaler_address.sv */
// NV12 nearest-neighbor scaler address generator: top level with config registers.
// Depends on nvsc_pkg and nvsc_div.
// Pipeline from input word accept to m_axis_tvalid: 1 multiply stage, 14 divider
// stages, a select stage and a multiply stage, then the output register.
// Throughput: one word per clock; a stalled output word holds the whole pipeline.
// Reset (synchronous, active low) empties the pipeline and restores register defaults.
module nv12_nearest_scaler_address
    import nvsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [12:0] dest_x, [25:13] dest_y, rest zero
    input  logic        s_axis_tuser,   // [0] mode
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [26:0] source_offset, [53:27] dest_offset, rest zero
    output logic [2:0]  m_axis_tuser    // [0] byte_pair, [2:1] status
);

    // ---------------- configuration registers ----------------
    logic [DIM_W-1:0] r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic [STR_W-1:0] r_luma_str, r_chroma_str, r_dst_str;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w      <= RST_SRC_W;
            r_src_h      <= RST_SRC_H;
            r_dst_w      <= RST_DST_W;
            r_dst_h      <= RST_DST_H;
            r_luma_str   <= RST_LUMA_STR;
            r_chroma_str <= RST_CHROMA_STR;
            r_dst_str    <= RST_DST_STR;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_SRC_W:      r_src_w      <= pwdata[DIM_W-1:0];
                REG_SRC_H:      r_src_h      <= pwdata[DIM_W-1:0];
                REG_DST_W:      r_dst_w      <= pwdata[DIM_W-1:0];
                REG_DST_H:      r_dst_h      <= pwdata[DIM_W-1:0];
                REG_LUMA_STR:   r_luma_str   <= pwdata[STR_W-1:0];
                REG_CHROMA_STR: r_chroma_str <= pwdata[STR_W-1:0];
                REG_DST_STR:    r_dst_str    <= pwdata[STR_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[4:2])
            REG_SRC_W:      prdata = 32'(r_src_w);
            REG_SRC_H:      prdata = 32'(r_src_h);
            REG_DST_W:      prdata = 32'(r_dst_w);
            REG_DST_H:      prdata = 32'(r_dst_h);
            REG_LUMA_STR:   prdata = 32'(r_luma_str);
            REG_CHROMA_STR: prdata = 32'(r_chroma_str);
            REG_DST_STR:    prdata = 32'(r_dst_str);
            default:        prdata = '0;
        endcase
    end

    // ---------------- saturated frame geometry ----------------
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v < DIM_LO) begin
            return DIM_LO;
        end else if (v > DIM_HI) begin
            return DIM_HI;
        end
        return v;
    endfunction

    function automatic logic [STR_W-1:0] clamp_str(input logic [STR_W-1:0] v);
        if (v < STR_LO) begin
            return STR_LO;
        end else if (v > STR_HI) begin
            return STR_HI;
        end
        return v;
    endfunction

    logic [DIM_W-1:0] n_sw, n_sh, n_dw, n_dh;
    logic [DIM_W-1:0] r_sw, r_sh, r_dw, r_dh, r_suh, r_duh;
    logic [STR_W-1:0] r_lstr, r_cstr, r_tstr;
    logic             r_half;

    assign n_sw = clamp_dim(r_src_w);
    assign n_sh = clamp_dim(r_src_h);
    assign n_dw = clamp_dim(r_dst_w);
    assign n_dh = clamp_dim(r_dst_h);

    // user must keep geometry stable while items flow (not enforced); registering keeps clamps off the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw   <= RST_SRC_W;
            r_sh   <= RST_SRC_H;
            r_dw   <= RST_DST_W;
            r_dh   <= RST_DST_H;
            r_suh  <= RST_SRC_H >> 1;
            r_duh  <= RST_DST_H >> 1;
            r_lstr <= RST_LUMA_STR;
            r_cstr <= RST_CHROMA_STR;
            r_tstr <= RST_DST_STR;
            r_half <= 1'b1;
        end else begin
            r_sw   <= n_sw;
            r_sh   <= n_sh;
            r_dw   <= n_dw;
            r_dh   <= n_dh;
            r_suh  <= n_sh >> 1;
            r_duh  <= n_dh >> 1;
            r_lstr <= clamp_str(r_luma_str);
            r_cstr <= clamp_str(r_chroma_str);
            r_tstr <= clamp_str(r_dst_str);
            r_half <= ({1'b0, n_sw} == {n_dw, 1'b0}) && ({1'b0, n_sh} == {n_dh, 1'b0});
        end
    end

    // ---------------- pipeline control ----------------
    logic r_out_valid;
    logic en;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- stage 1: numerators and frame checks ----------------
    logic [COORD_W-1:0] in_x, in_y;
    logic               in_mode;
    logic [DIM_W-1:0]   in_ny_mul, in_den_y, in_rows;
    logic [1:0]         in_status;

    assign in_x      = s_axis_tdata[COORD_W-1:0];
    assign in_y      = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign in_mode   = s_axis_tuser;
    assign in_ny_mul = in_mode ? r_suh : r_sh;
    assign in_den_y  = in_mode ? r_duh : r_dh;
    assign in_rows   = in_mode ? r_duh : r_dh;

    always_comb begin
        if (({1'b0, in_x} >= r_dw) || ({1'b0, in_y} >= in_rows)) begin
            in_status = ST_OUTSIDE;
        end else if (in_mode && in_x[0]) begin
            in_status = ST_ODD;
        end else begin
            in_status = ST_OK;
        end
    end

    logic               r_v1;
    logic [NUM_W-1:0]   r_num_x, r_num_y;
    logic [DIM_W-1:0]   r_den_y;
    t_side              r_s1_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num_x   <= NUM_W'(in_x) * NUM_W'(r_sw);
            r_num_y   <= NUM_W'(in_y) * NUM_W'(in_ny_mul);
            r_den_y   <= in_den_y;
            r_s1_side <= '{mode: in_mode, x: in_x, y: in_y, status: in_status};
        end
    end

    // ---------------- divider stages ----------------
    logic [QUO_W-1:0] w_qx, w_qy;

    nvsc_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num_x),
        .i_den (r_dw),
        .o_quo (w_qx)
    );

    nvsc_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num_y),
        .i_den (r_den_y),
        .o_quo (w_qy)
    );

    // sideband rides beside the dividers
    t_side r_side [QUO_W];
    logic  r_vld  [QUO_W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r_s1_side;
            for (int i = 1; i < QUO_W; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // ---------------- stage A: source row and column ----------------
    t_side            a_side;
    logic [DIM_W-1:0] a_sy, a_sx, a_lim_y, a_lim_x, a_qx_even;

    assign a_side    = r_side[QUO_W-1];
    assign a_qx_even = {w_qx[QUO_W-1:1], 1'b0};
    assign a_lim_y   = a_side.mode ? (r_suh - DIM_W'(1)) : (r_sh - DIM_W'(1));
    assign a_lim_x   = a_side.mode ? (r_sw - DIM_W'(2)) : (r_sw - DIM_W'(1));

    always_comb begin
        if (r_half) begin
            a_sy = {a_side.y, 1'b0};
            a_sx = {a_side.x, 1'b0};
        end else if (!a_side.mode) begin
            a_sy = (w_qy < a_lim_y) ? w_qy : a_lim_y;
            a_sx = (w_qx < a_lim_x) ? w_qx : a_lim_x;
        end else begin
            a_sy = (w_qy < a_lim_y) ? w_qy : a_lim_y;
            a_sx = (a_qx_even < a_lim_x) ? a_qx_even : a_lim_x;
        end
    end

    logic             r_a_v;
    logic [DIM_W-1:0] r_a_sy, r_a_sx;
    logic [STR_W-1:0] r_a_str;
    t_side            r_a_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_sy   <= a_sy;
            r_a_sx   <= a_sx;
            r_a_str  <= a_side.mode ? r_cstr : r_lstr;
            r_a_side <= a_side;
        end
    end

    // ---------------- stage B: row offsets ----------------
    localparam int SPROD_W = DIM_W + STR_W;
    localparam int DPROD_W = COORD_W + STR_W;

    logic               r_b_v;
    logic [SPROD_W-1:0] r_b_sprod;
    logic [DPROD_W-1:0] r_b_dprod;
    logic [DIM_W-1:0]   r_b_sx;
    t_side              r_b_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_sprod <= SPROD_W'(r_a_sy) * SPROD_W'(r_a_str);
            r_b_dprod <= DPROD_W'(r_a_side.y) * DPROD_W'(r_tstr);
            r_b_sx    <= r_a_sx;
            r_b_side  <= r_a_side;
        end
    end

    // ---------------- stage C: final offsets into output register ----------------
    logic [SPROD_W-1:0] c_ssum;
    logic [DPROD_W-1:0] c_dsum;
    logic               c_ok;

    assign c_ssum = r_b_sprod + SPROD_W'(r_b_sx);
    assign c_dsum = r_b_dprod + DPROD_W'(r_b_side.x);
    assign c_ok   = (r_b_side.status == ST_OK);

    logic [OFF_W-1:0] r_out_soff, r_out_doff;
    logic             r_out_pair;
    logic [1:0]       r_out_status;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_soff   <= c_ok ? c_ssum[OFF_W-1:0] : '0;
            r_out_doff   <= c_ok ? c_dsum[OFF_W-1:0] : '0;
            r_out_pair   <= r_b_side.mode;
            r_out_status <= r_b_side.status;
        end
    end

    // valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_a_v       <= 1'b0;
            r_b_v       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < QUO_W; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_v1     <= s_axis_tvalid;
            r_vld[0] <= r_v1;
            for (int i = 1; i < QUO_W; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_a_v       <= r_vld[QUO_W-1];
            r_b_v       <= r_a_v;
            r_out_valid <= r_b_v;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_doff, r_out_soff};
    assign m_axis_tuser  = {r_out_status, r_out_pair};

    // ---------------- assertions ----------------
    // flagged words carry no offsets
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out_status != ST_OK)) |-> ((r_out_soff == '0) && (r_out_doff == '0)))
        else $error("flagged word carries a nonzero offset");

    // odd-column flag only for chroma pairs
    a_odd_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out_status == ST_ODD)) |-> r_out_pair)
        else $error("odd-column status on a luma word");

    // a held output word blocks new input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule
